### rtl/dgt_pkg.sv
// ----------------------------------------------------------------------------
// dgt_pkg: shared types and constants for the directed graph node/edge table
// Sizes, result codes, the sequencer control word and its program.
// ----------------------------------------------------------------------------
`default_nettype none

package dgt_pkg;

  // table sizes
  localparam int MAX_NODES   = 16;
  localparam int KEY_BITS    = 32;
  localparam int IDX_BITS    = $clog2(MAX_NODES);
  localparam int CNT_BITS    = $clog2(MAX_NODES + 1);
  localparam int EDGE_BITS   = $clog2(MAX_NODES * MAX_NODES + 1);
  localparam int LIMIT_BITS  = 5;
  localparam int CMP_BITS    = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;
  localparam int STATUS_BITS = 2;
  localparam int STEP_BITS   = 4;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16);

  // item opcodes
  localparam logic OP_ADD_NODE = 1'b0;
  localparam logic OP_ADD_EDGE = 1'b1;

  // result codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_ADDED     = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // datapath actions
  typedef enum logic [3:0] {
    ACT_NONE   = 4'd0,
    ACT_TAKE   = 4'd1,
    ACT_SCAN_A = 4'd2,
    ACT_SCAN_B = 4'd3,
    ACT_SAVE_A = 4'd4,
    ACT_NODE   = 4'd5,
    ACT_FULL   = 4'd6,
    ACT_EDGE   = 4'd7,
    ACT_EMIT   = 4'd8
  } act_t;

  // jump conditions
  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_ALWAYS   = 3'd1,
    J_NO_ITEM  = 3'd2,
    J_FULL     = 3'd3,
    J_BUSY     = 3'd4,
    J_IS_NODE  = 3'd5,
    J_OUT_FREE = 3'd6
  } jmp_t;

  typedef logic [STEP_BITS-1:0] step_t;

  // program steps
  localparam step_t S_IDLE   = 4'd0;
  localparam step_t S_CHECK  = 4'd1;
  localparam step_t S_SCAN_A = 4'd2;
  localparam step_t S_WAIT_A = 4'd3;
  localparam step_t S_SAVE_A = 4'd4;
  localparam step_t S_SCAN_B = 4'd5;
  localparam step_t S_WAIT_B = 4'd6;
  localparam step_t S_EDGE   = 4'd7;
  localparam step_t S_NODE   = 4'd8;
  localparam step_t S_FULL   = 4'd9;
  localparam step_t S_EMIT   = 4'd10;
  localparam step_t S_RETRY  = 4'd11;
  localparam step_t S_LAST   = S_RETRY;

  // one control word
  typedef struct packed {
    act_t  act;
    jmp_t  jmp;
    step_t target;
  } uword_t;

  // condition flags seen by the sequencer
  typedef struct packed {
    logic item;
    logic full;
    logic busy;
    logic is_node;
    logic out_free;
  } cond_t;

  // control store
  function automatic uword_t dgt_rom(input step_t step);
    uword_t w;
    case (step)
      S_IDLE:   w = '{ACT_TAKE,   J_NO_ITEM,  S_IDLE};
      S_CHECK:  w = '{ACT_NONE,   J_FULL,     S_FULL};
      S_SCAN_A: w = '{ACT_SCAN_A, J_NEXT,     S_IDLE};
      S_WAIT_A: w = '{ACT_NONE,   J_BUSY,     S_WAIT_A};
      S_SAVE_A: w = '{ACT_SAVE_A, J_IS_NODE,  S_NODE};
      S_SCAN_B: w = '{ACT_SCAN_B, J_NEXT,     S_IDLE};
      S_WAIT_B: w = '{ACT_NONE,   J_BUSY,     S_WAIT_B};
      S_EDGE:   w = '{ACT_EDGE,   J_ALWAYS,   S_EMIT};
      S_NODE:   w = '{ACT_NODE,   J_ALWAYS,   S_EMIT};
      S_FULL:   w = '{ACT_FULL,   J_NEXT,     S_IDLE};
      S_EMIT:   w = '{ACT_EMIT,   J_OUT_FREE, S_IDLE};
      S_RETRY:  w = '{ACT_NONE,   J_ALWAYS,   S_EMIT};
      default:  w = '{ACT_NONE,   J_ALWAYS,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/dgt_cmd_if.sv
// ----------------------------------------------------------------------------
// dgt_cmd_if: command channel
// Carries one add-node or add-edge item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dgt_cmd_if import dgt_pkg::*; ;
  logic                valid;
  logic                ready;
  logic                op;
  logic [KEY_BITS-1:0] node_key;
  logic [KEY_BITS-1:0] dest_key;

  modport source (output valid, op, node_key, dest_key, input ready);
  modport sink   (input valid, op, node_key, dest_key, output ready);
endinterface

`default_nettype wire

### rtl/dgt_rsp_if.sv
// ----------------------------------------------------------------------------
// dgt_rsp_if: response channel
// Carries one result per beat: status, indices and table counts.
// ----------------------------------------------------------------------------
`default_nettype none

interface dgt_rsp_if import dgt_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [IDX_BITS-1:0]    source_index;
  logic [IDX_BITS-1:0]    dest_index;
  logic [CNT_BITS-1:0]    nodes_held;
  logic [EDGE_BITS-1:0]   edges_held;

  modport source (output valid, status, source_index, dest_index, nodes_held, edges_held,
                  input ready);
  modport sink   (input valid, status, source_index, dest_index, nodes_held, edges_held,
                  output ready);
endinterface

`default_nettype wire

### rtl/directed_graph_node_edge_table.sv
// ----------------------------------------------------------------------------
// directed_graph_node_edge_table: node key table with directed edge set
// Adds node keys at the next free index and sets edges between stored nodes
// in an adjacency bit matrix, one result beat per command beat.
//
//   channel  dir  handshake        payload
//   cmd      in   valid/ready      op, node_key, dest_key
//   rsp      out  valid/ready      status, source_index, dest_index,
//                                  nodes_held, edges_held
//   cfg      in   cfg_we           cfg_wdata (node_limit)
//
// Each lookup reads the key RAM one stored key per cycle.
// One item at a time: cmd is taken only when the sequencer is at idle.
// Reset is synchronous: counts and the edge matrix clear at once, key RAM not.
// A held rsp beat stalls only the emit step; the result register frees cmd.
// ----------------------------------------------------------------------------
`default_nettype none

module directed_graph_node_edge_table import dgt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  dgt_cmd_if.sink               cmd,
  dgt_rsp_if.source             rsp,
  input  logic                  cfg_we,
  input  logic [LIMIT_BITS-1:0] cfg_wdata
);

  logic [LIMIT_BITS-1:0] node_limit;
  logic                  op;
  logic [KEY_BITS-1:0]   key_a;
  logic [KEY_BITS-1:0]   key_b;
  logic                  a_found;
  logic [IDX_BITS-1:0]   a_idx;
  logic [CNT_BITS-1:0]   node_total;
  logic [EDGE_BITS-1:0]  edge_total;
  logic [MAX_NODES-1:0]  edge_rows [MAX_NODES];
  status_t               res_status;
  logic [IDX_BITS-1:0]   res_si;
  logic [IDX_BITS-1:0]   res_di;
  logic                  out_v;

  act_t                  act;
  cond_t                 cond;
  logic                  scan_busy;
  logic                  scan_found;
  logic [IDX_BITS-1:0]   scan_idx;
  logic                  scan_start;
  logic                  key_wr;
  logic [CMP_BITS-1:0]   eff_limit;
  logic                  full;
  logic                  out_free;
  logic                  edge_set;

  dgt_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .act  (act)
  );

  dgt_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .key       ((act == ACT_SCAN_B) ? key_b : key_a),
    .count     (node_total),
    .wr_en     (key_wr),
    .wr_addr   (node_total[IDX_BITS-1:0]),
    .wr_data   (key_a),
    .busy      (scan_busy),
    .found     (scan_found),
    .found_idx (scan_idx)
  );

  // limit capped at table size
  always_comb begin
    eff_limit = (CMP_BITS'(node_limit) > CMP_BITS'(MAX_NODES)) ? CMP_BITS'(MAX_NODES)
                                                                 : CMP_BITS'(node_limit);
    full      = (op == OP_ADD_NODE) && (CMP_BITS'(node_total) >= eff_limit);
  end

  assign out_free   = ~out_v | rsp.ready;
  assign scan_start = (act == ACT_SCAN_A) || (act == ACT_SCAN_B);
  assign key_wr     = (act == ACT_NODE) && !a_found;
  assign edge_set   = edge_rows[a_idx][scan_idx];

  // sequencer flags
  always_comb begin
    cond.item     = cmd.valid;
    cond.full     = full;
    cond.busy     = scan_busy;
    cond.is_node  = (op == OP_ADD_NODE);
    cond.out_free = out_free;
  end

  assign cmd.ready = (act == ACT_TAKE) && !rst;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      node_limit <= cfg_wdata;
    end
  end

  // item capture and first lookup result
  always_ff @(posedge clk) begin
    if (act == ACT_TAKE && cmd.valid) begin
      op    <= cmd.op;
      key_a <= cmd.node_key;
      key_b <= cmd.dest_key;
    end
    if (act == ACT_SAVE_A) begin
      a_found <= scan_found;
      a_idx   <= scan_idx;
    end
  end

  // counters and edge matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      node_total <= '0;
      edge_total <= '0;
      for (int r = 0; r < MAX_NODES; r++) begin
        edge_rows[r] <= '0;
      end
    end else begin
      if (key_wr) begin
        node_total <= node_total + 1'b1;
      end
      if (act == ACT_EDGE && a_found && scan_found && !edge_set) begin
        edge_rows[a_idx][scan_idx] <= 1'b1;
        edge_total                 <= edge_total + 1'b1;
      end
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    case (act)
      ACT_NODE: begin
        res_status <= a_found ? ST_PRESENT : ST_ADDED;
        res_si     <= a_found ? a_idx : node_total[IDX_BITS-1:0];
        res_di     <= '0;
      end
      ACT_FULL: begin
        res_status <= ST_FULL;
        res_si     <= '0;
        res_di     <= '0;
      end
      ACT_EDGE: begin
        if (!a_found || !scan_found) begin
          res_status <= ST_NOT_FOUND;
        end else if (edge_set) begin
          res_status <= ST_PRESENT;
        end else begin
          res_status <= ST_ADDED;
        end
        res_si <= a_found ? a_idx : '0;
        res_di <= scan_found ? scan_idx : '0;
      end
      default: begin
      end
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (act == ACT_EMIT && out_free) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act == ACT_EMIT && out_free) begin
      rsp.status       <= res_status;
      rsp.source_index <= res_si;
      rsp.dest_index   <= res_di;
      rsp.nodes_held   <= node_total;
      rsp.edges_held   <= edge_total;
    end
  end

  assign rsp.valid = out_v;

`ifndef NO_ASSERTIONS
  a_node_cap: assert property (@(posedge clk) disable iff (rst)
    node_total <= CNT_BITS'(MAX_NODES))
    else $error("node count beyond table size");

  a_edge_step: assert property (@(posedge clk) disable iff (rst)
    (edge_total == $past(edge_total)) || (edge_total == $past(edge_total) + 1'b1))
    else $error("edge count moved by more than one");

  a_write_free_slot: assert property (@(posedge clk) disable iff (rst)
    key_wr |-> (CMP_BITS'(node_total) < eff_limit))
    else $error("key written with table at its limit");
`endif

endmodule

`default_nettype wire

### rtl/dgt_ram.sv
// ----------------------------------------------------------------------------
// dgt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dgt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/dgt_scan.sv
// ----------------------------------------------------------------------------
// dgt_scan: key store and lookup unit
// Holds node keys in a RAM and searches the stored entries one per cycle
// with a single comparator, in the cycle after the read.
// ----------------------------------------------------------------------------
`default_nettype none

module dgt_scan import dgt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KEY_BITS-1:0] key,
  input  logic [CNT_BITS-1:0] count,
  input  logic                wr_en,
  input  logic [IDX_BITS-1:0] wr_addr,
  input  logic [KEY_BITS-1:0] wr_data,
  output logic                busy,
  output logic                found,
  output logic [IDX_BITS-1:0] found_idx
);

  logic [IDX_BITS-1:0] idx;
  logic                run;
  logic                cmp_v;
  logic [IDX_BITS-1:0] cmp_idx;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] rdata;
  logic                last;

  dgt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_NODES)
  ) u_keys (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (run),
    .raddr (idx),
    .rdata (rdata)
  );

  assign last = ({1'b0, idx} == CNT_BITS'(count - 1'b1));
  assign busy = run | cmp_v;

  // read address walk
  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      cmp_v <= 1'b0;
    end else if (start) begin
      run   <= (count != '0);
      cmp_v <= 1'b0;
    end else begin
      run   <= run & ~last;
      cmp_v <= run;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx   <= '0;
      key_r <= key;
    end else if (run) begin
      idx <= idx + 1'b1;
    end
    cmp_idx <= idx;
  end

  // compare stage, first hit wins
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (start) begin
      found <= 1'b0;
    end else if (cmp_v && !found && rdata == key_r) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_v && !found && rdata == key_r) begin
      found_idx <= cmp_idx;
    end
  end

`ifndef NO_ASSERTIONS
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    found |-> ({1'b0, found_idx} < count))
    else $error("lookup hit beyond stored entries");
`endif

endmodule

`default_nettype wire

### rtl/dgt_seq.sv
// ----------------------------------------------------------------------------
// dgt_seq: microcode sequencer
// Step counter over the control store, with conditional jumps on datapath
// flags; hands the current action to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module dgt_seq import dgt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cond_t cond,
  output act_t  act
);

  step_t  pc;
  step_t  pc_next;
  uword_t word;
  logic   jump;

  assign word = dgt_rom(pc);
  assign act  = word.act;

  // jump condition select
  always_comb begin
    case (word.jmp)
      J_NEXT:     jump = 1'b0;
      J_ALWAYS:   jump = 1'b1;
      J_NO_ITEM:  jump = ~cond.item;
      J_FULL:     jump = cond.full;
      J_BUSY:     jump = cond.busy;
      J_IS_NODE:  jump = cond.is_node;
      J_OUT_FREE: jump = cond.out_free;
      default:    jump = 1'b0;
    endcase
    pc_next = jump ? word.target : step_t'(pc + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= S_LAST)
    else $error("step counter left the program");
`endif

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for directed_graph_node_edge_table
// Drives add-node and add-edge beats through the command channel and checks
// every response beat against an in-bench graph predictor. Covers limits of
// zero, one, out of range and below the stored count, full-before-duplicate,
// self loops, missing keys and a long response hold-off that backs up cmd.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dgt_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;

  // expected response beat
  typedef struct packed {
    status_t               status;
    logic [IDX_BITS-1:0]   source_index;
    logic [IDX_BITS-1:0]   dest_index;
    logic [CNT_BITS-1:0]   nodes_held;
    logic [EDGE_BITS-1:0]  edges_held;
  } graph_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [LIMIT_BITS-1:0] cfg_wdata;

  dgt_cmd_if cmd_ch ();
  dgt_rsp_if rsp_ch ();

  directed_graph_node_edge_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [KEY_BITS-1:0]  key_store [MAX_NODES];
  logic [MAX_NODES-1:0] adjacency [MAX_NODES];
  int unsigned          node_count;
  int unsigned          edge_count;
  logic [LIMIT_BITS-1:0] node_limit;

  graph_result_t pending_results [$];
  int unsigned   mismatch_count = 0;
  bit            gaps_on = 1'b1;
  bit            hold_request = 1'b0;
  int unsigned   idle_cycles = 0;

  // index of a stored key, or -1
  function automatic int find_key(input logic [KEY_BITS-1:0] key);
    for (int i = 0; i < node_count; i++) begin
      if (key_store[i] == key) return i;
    end
    return -1;
  endfunction

  // apply one command to the predictor and return the response it gives
  function automatic graph_result_t predict_graph(input logic op,
                                                  input logic [KEY_BITS-1:0] a,
                                                  input logic [KEY_BITS-1:0] b);
    graph_result_t r;
    int src_hit;
    int dst_hit;
    int unsigned cap;
    r = '0;
    cap = (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
    if (op == OP_ADD_NODE) begin
      // full is reported ahead of duplicate
      if (node_count >= cap) begin
        r.status = ST_FULL;
      end else begin
        src_hit = find_key(a);
        if (src_hit >= 0) begin
          r.status = ST_PRESENT;
          r.source_index = IDX_BITS'(src_hit);
        end else begin
          key_store[node_count] = a;
          r.source_index = IDX_BITS'(node_count);
          node_count++;
          r.status = ST_ADDED;
        end
      end
    end else begin
      src_hit = find_key(a);
      dst_hit = find_key(b);
      if (src_hit >= 0) r.source_index = IDX_BITS'(src_hit);
      if (dst_hit >= 0) r.dest_index = IDX_BITS'(dst_hit);
      if (src_hit < 0 || dst_hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else if (adjacency[src_hit][dst_hit]) begin
        r.status = ST_PRESENT;
      end else begin
        adjacency[src_hit][dst_hit] = 1'b1;
        edge_count++;
        r.status = ST_ADDED;
      end
    end
    r.nodes_held = CNT_BITS'(node_count);
    r.edges_held = EDGE_BITS'(edge_count);
    return r;
  endfunction

  // mostly a stored key, sometimes a fresh random one
  function automatic logic [KEY_BITS-1:0] pick_key();
    if (node_count != 0 && $urandom_range(0, 9) < 8)
      return key_store[$urandom_range(0, node_count - 1)];
    return $urandom();
  endfunction

  // send one command beat and record its expected response on acceptance
  task automatic send_cmd(input logic op, input logic [KEY_BITS-1:0] a,
                          input logic [KEY_BITS-1:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.op       <= op;
    cmd_ch.node_key <= a;
    cmd_ch.dest_key <= b;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    pending_results.push_back(predict_graph(op, a, b));
  endtask

  // stop offering and wait until every response is back
  task automatic wait_all_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write node_limit while the block is idle
  task automatic set_limit(input logic [LIMIT_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    node_limit = value;
    cfg_we <= 1'b0;
  endtask

  // one random command, biased toward keys already stored
  task automatic send_random_cmd();
    logic op;
    logic [KEY_BITS-1:0] a;
    logic [KEY_BITS-1:0] b;
    if (node_count < MAX_NODES && node_count < node_limit)
      op = ($urandom_range(0, 99) < 35) ? OP_ADD_NODE : OP_ADD_EDGE;
    else
      op = ($urandom_range(0, 99) < 10) ? OP_ADD_NODE : OP_ADD_EDGE;
    if (op == OP_ADD_NODE)
      a = ($urandom_range(0, 9) < 6) ? $urandom() : pick_key();
    else
      a = pick_key();
    b = ($urandom_range(0, 9) < 2) ? $urandom() : pick_key();
    send_cmd(op, a, b);
  endtask

  task automatic send_random_run(input int count);
    repeat (count) send_random_cmd();
  endtask

  // tests
  task automatic test_empty_table();
    send_cmd(OP_ADD_EDGE, 32'd1, 32'd2);
    wait_all_results();
  endtask

  task automatic test_zero_limit();
    set_limit(5'd0);
    send_cmd(OP_ADD_NODE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(OP_ADD_NODE, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_all_results();
  endtask

  task automatic test_single_slot();
    set_limit(5'd1);
    send_cmd(OP_ADD_NODE, 32'h0000_0000, 32'h0);
    // already stored but the table is full
    send_cmd(OP_ADD_NODE, 32'h0000_0000, 32'h0);
    send_cmd(OP_ADD_NODE, 32'h0000_0007, 32'h0);
    wait_all_results();
  endtask

  task automatic test_two_nodes_and_edges();
    set_limit(5'd2);
    send_cmd(OP_ADD_NODE, 32'h0000_0000, 32'h0);
    send_cmd(OP_ADD_NODE, 32'hFFFF_FFFF, 32'h0);
    send_cmd(OP_ADD_NODE, 32'h0000_0005, 32'h0);
    send_cmd(OP_ADD_EDGE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(OP_ADD_EDGE, 32'h0000_0000, 32'hFFFF_FFFF);
    // self loop
    send_cmd(OP_ADD_EDGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // one side missing, the other index still reported
    send_cmd(OP_ADD_EDGE, 32'h0000_0000, 32'h0001_2345);
    send_cmd(OP_ADD_EDGE, 32'h0001_2345, 32'hFFFF_FFFF);
    send_cmd(OP_ADD_EDGE, 32'h0BAD_0001, 32'h0BAD_0002);
    wait_all_results();
  endtask

  task automatic test_capped_limit();
    set_limit(5'd31);
    send_cmd(OP_ADD_NODE, 32'h8000_0000, 32'h0);
    send_cmd(OP_ADD_EDGE, 32'hFFFF_FFFF, 32'h8000_0000);
    send_cmd(OP_ADD_NODE, 32'h7FFF_FFFF, 32'h0);
    wait_all_results();
  endtask

  task automatic test_random_small_limit();
    set_limit(LIMIT_BITS'($urandom_range(4, 10)));
    send_random_run(100);
    wait_all_results();
  endtask

  task automatic test_random_full_table();
    set_limit(5'd31);
    send_random_run(100);
    wait_all_results();
  endtask

  // response side holds off while commands keep coming
  task automatic test_receiver_hold();
    gaps_on = 1'b0;
    hold_request = 1'b1;
    send_random_run(20);
    wait_all_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_lowered_limit();
    set_limit(5'd4);
    send_random_run(100);
    wait_all_results();
  endtask

  task automatic test_final_no_gaps();
    set_limit(5'd16);
    gaps_on = 1'b0;
    send_random_run(150);
    wait_all_results();
  endtask

  // response ready with random stalls and one long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic report_field(input string field, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("mismatch %s: expected %0d actual %0d", field, exp_v, act_v);
    end
  endtask

  // compare each response beat with the oldest expectation
  always @(posedge clk) begin
    graph_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("mismatch: response beat with nothing expected, status %0d",
                   rsp_ch.status);
      end else begin
        want = pending_results.pop_front();
        report_field("status", want.status, rsp_ch.status);
        report_field("source_index", want.source_index, rsp_ch.source_index);
        report_field("dest_index", want.dest_index, rsp_ch.dest_index);
        report_field("nodes_held", want.nodes_held, rsp_ch.nodes_held);
        report_field("edges_held", want.edges_held, rsp_ch.edges_held);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[directed_graph_node_edge_table] ERROR");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.op       <= OP_ADD_NODE;
    cmd_ch.node_key <= '0;
    cmd_ch.dest_key <= '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      key_store[i] = '0;
      adjacency[i] = '0;
    end
    node_count = 0;
    edge_count = 0;
    node_limit = LIMIT_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_zero_limit();
    test_single_slot();
    test_two_nodes_and_edges();
    test_capped_limit();
    test_random_small_limit();
    test_random_full_table();
    test_receiver_hold();
    test_lowered_limit();
    test_final_no_gaps();

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("[directed_graph_node_edge_table] OK");
    else
      $display("[directed_graph_node_edge_table] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
